// File: design/mbcrc_pkg.sv
// Shared types, codes and the CRC-16 byte update for the Modbus RTU CRC engine.
// No dependencies.
`default_nettype none

package mbcrc_pkg;

  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [8:0]  COUNT_SAT = 9'd511;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  typedef enum logic [1:0] {
    KIND_ECHO   = 2'd0,
    KIND_CRC    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_TOO_BIG   = 3'd2,
    ST_TOO_SMALL = 3'd3,
    ST_BAD_SIZE  = 3'd4,
    ST_BAD_CRC   = 3'd5
  } status_e;

  // what follows the optional echo of a word
  typedef enum logic [1:0] {
    TAIL_NONE   = 2'd0,
    TAIL_STATUS = 2'd1,
    TAIL_CRC    = 2'd2
  } tail_e;

  typedef enum logic [1:0] {
    PH_ECHO   = 2'd0,
    PH_TAIL   = 2'd1,
    PH_CRC_HI = 2'd2
  } phase_e;

  typedef struct packed {
    logic        has_echo;
    logic [7:0]  data;
    tail_e       tail;
    status_e     status;
    logic [15:0] crc;
    logic [8:0]  len;
  } entry_t;

  // reflected CRC-16 over one byte, bit at a time
  function automatic logic [15:0] crc_byte(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    c = c_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: design/mbcrc_front.sv
// Front end: accepts frame words, runs the CRC and byte count, classifies the
// frame end and pushes one entry per word that has results. Uses mbcrc_pkg.
`default_nettype none

module mbcrc_front import mbcrc_pkg::*; #(
  parameter int unsigned MAX_FRAME = 256,
  parameter int unsigned MIN_FRAME = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       op_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_i,
  input  wire logic [7:0] pdu_size_i,
  input  wire logic       q_full_i,
  output logic            push_o,
  output entry_t          entry_o
);

  localparam logic [9:0] MaxLen = 10'(MAX_FRAME);
  localparam logic [9:0] MinLen = 10'(MIN_FRAME);

  logic [15:0] crc_q, crc_d;
  logic [8:0]  cnt_q, cnt_d;
  logic [7:0]  exp_q, exp_d;
  logic        mode_q, mode_d;
  logic        in_frame_q;

  logic        accept;
  logic [15:0] crc_base;
  logic [8:0]  cnt_base;
  logic [8:0]  adu;
  logic [9:0]  n_plus2;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // a word outside a frame opens a new one
  assign mode_d   = in_frame_q ? mode_q : op_i;
  assign exp_d    = in_frame_q ? exp_q : pdu_size_i;
  assign crc_base = in_frame_q ? crc_q : CRC_INIT;
  assign cnt_base = in_frame_q ? cnt_q : 9'd0;
  assign adu      = {1'b0, exp_d} + 9'd3;

  // check mode ignores bytes past address + PDU + CRC
  assign crc_d   = (mode_d == OP_BUILD || cnt_base < adu) ? crc_byte(crc_base, data_byte_i)
                                                           : crc_base;
  assign cnt_d   = (cnt_base != COUNT_SAT) ? cnt_base + 9'd1 : cnt_base;
  assign n_plus2 = {1'b0, cnt_d} + 10'd2;

  always_comb begin
    entry_o          = '0;
    entry_o.data     = data_byte_i;
    entry_o.crc      = crc_d;
    entry_o.tail     = TAIL_NONE;
    entry_o.status   = ST_OK;
    entry_o.has_echo = (mode_d == OP_BUILD);
    if (last_i) begin
      entry_o.tail = TAIL_STATUS;
      if (mode_d == OP_BUILD) begin
        if (cnt_d == 9'd1)          entry_o.status = ST_EMPTY;
        else if (n_plus2 > MaxLen)  entry_o.status = ST_TOO_BIG;
        else if (n_plus2 < MinLen)  entry_o.status = ST_TOO_SMALL;
        else begin
          entry_o.tail = TAIL_CRC;
          entry_o.len  = n_plus2[8:0];
        end
      end else begin
        if ({1'b0, cnt_d} < MinLen || cnt_d < adu) entry_o.status = ST_BAD_SIZE;
        else if (crc_d != 16'h0000)                entry_o.status = ST_BAD_CRC;
        else                                        entry_o.len    = adu;
      end
    end
  end

  assign push_o = accept && (mode_d == OP_BUILD || last_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CRC_INIT;
      cnt_q      <= '0;
      exp_q      <= '0;
      mode_q     <= OP_BUILD;
      in_frame_q <= 1'b0;
    end else if (accept) begin
      crc_q      <= crc_d;
      cnt_q      <= cnt_d;
      exp_q      <= exp_d;
      mode_q     <= mode_d;
      in_frame_q <= !last_i;
    end
  end

endmodule

`default_nettype wire

// File: design/mbcrc_queue.sv
// Two-entry queue between front and back end of the CRC engine.
// Uses mbcrc_pkg for the entry type.
`default_nettype none

module mbcrc_queue import mbcrc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  output logic        full_o,
  input  wire logic   pop_i,
  output logic        head_valid_o,
  output entry_t      head_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

// File: design/mbcrc_back.sv
// Back end: expands each queued entry into its result words (echo, status or
// CRC low/high) through a registered output stage. Uses mbcrc_pkg.
`default_nettype none

module mbcrc_back import mbcrc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   head_valid_i,
  input  wire entry_t head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  wire logic   out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic [1:0]  kind_o,
  output logic        frame_end_o,
  output logic [2:0]  status_o,
  output logic [8:0]  frame_length_o
);

  phase_e phase_q, phase_d, phase_eff;
  logic   last_of_entry;
  logic   load;

  logic       out_valid_q;
  logic [7:0] byte_q, byte_d;
  kind_e      kind_q, kind_d;
  logic       end_q, end_d;
  status_e    status_q, status_d;
  logic [8:0] len_q, len_d;

  assign load  = head_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && last_of_entry;

  // next-state logic
  always_comb begin
    phase_eff = phase_q;
    if (phase_q == PH_ECHO && !head_i.has_echo) phase_eff = PH_TAIL;
    case (phase_eff)
      PH_ECHO:   last_of_entry = (head_i.tail == TAIL_NONE);
      PH_TAIL:   last_of_entry = (head_i.tail == TAIL_STATUS);
      PH_CRC_HI: last_of_entry = 1'b1;
      default:   last_of_entry = 1'b1;
    endcase
    phase_d = phase_q;
    if (load) begin
      if (last_of_entry) phase_d = PH_ECHO;
      else begin
        case (phase_eff)
          PH_ECHO: phase_d = PH_TAIL;
          PH_TAIL: phase_d = PH_CRC_HI;
          default: phase_d = PH_ECHO;
        endcase
      end
    end
  end

  // output word for the current phase
  always_comb begin
    byte_d   = 8'h00;
    kind_d   = KIND_STATUS;
    end_d    = 1'b0;
    status_d = ST_OK;
    len_d    = '0;
    case (phase_eff)
      PH_ECHO: begin
        byte_d = head_i.data;
        kind_d = KIND_ECHO;
      end
      PH_TAIL: begin
        if (head_i.tail == TAIL_CRC) begin
          byte_d = head_i.crc[7:0];
          kind_d = KIND_CRC;
        end else begin
          end_d    = 1'b1;
          status_d = head_i.status;
          len_d    = head_i.len;
        end
      end
      PH_CRC_HI: begin
        byte_d = head_i.crc[15:8];
        kind_d = KIND_CRC;
        end_d  = 1'b1;
        len_d  = head_i.len;
      end
      default: begin
        kind_d = KIND_STATUS;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_ECHO;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= byte_d;
      kind_q   <= kind_d;
      end_q    <= end_d;
      status_q <= status_d;
      len_q    <= len_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = byte_q;
  assign kind_o         = kind_q;
  assign frame_end_o    = end_q;
  assign status_o       = status_q;
  assign frame_length_o = len_q;

endmodule

`default_nettype wire

// File: design/modbus_rtu_frame_crc_engine_top.sv
// Modbus RTU CRC-16 framing engine, top level.
// A word's results pass through the two-entry queue and the registered output stage.
// Throughput: one word per cycle; a build-mode frame end gives up to three
// results, drained one per cycle by the back end as the receiver takes them,
// so input stalls once the two-entry queue fills. Async active-low reset
// empties the queue and output stage and clears frame state (CRC to 0xFFFF).
`default_nettype none

module modbus_rtu_frame_crc_engine_top import mbcrc_pkg::*; #(
  parameter int unsigned MAX_FRAME = 256,
  parameter int unsigned MIN_FRAME = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic       op_i,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_i,
  input  wire logic [7:0] pdu_size_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic [1:0]      kind_o,
  output logic            frame_end_o,
  output logic [2:0]      status_o,
  output logic [8:0]      frame_length_o
);

  logic   q_full, q_push, q_pop, q_head_valid;
  entry_t q_entry, q_head;

  mbcrc_front #(
    .MAX_FRAME (MAX_FRAME),
    .MIN_FRAME (MIN_FRAME)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (op_i),
    .data_byte_i (data_byte_i),
    .last_i      (last_i),
    .pdu_size_i  (pdu_size_i),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .entry_o     (q_entry)
  );

  mbcrc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .entry_i      (q_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_head_valid),
    .head_o       (q_head)
  );

  mbcrc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (q_head_valid),
    .head_i         (q_head),
    .pop_o          (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .kind_o         (kind_o),
    .frame_end_o    (frame_end_o),
    .status_o       (status_o),
    .frame_length_o (frame_length_o)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("push into full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_head_valid)
    else $error("pop from empty queue");

  a_err_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_end_o && status_o != ST_OK) |-> frame_length_o == 9'd0)
    else $error("length reported on error result");

  a_crc_hi_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == KIND_CRC && frame_end_o) |-> frame_length_o != 9'd0)
    else $error("CRC high byte without frame length");
`endif

endmodule

`default_nettype wire

// File: test/modbus_rtu_frame_crc_engine_top_test.sv
// Self-checking testbench for modbus_rtu_frame_crc_engine_top: build and check
// frames, random stalls. Depends on mbcrc_pkg and the engine top level; a
// scoreboard class predicts every output word.
`timescale 1ns / 100ps

module modbus_rtu_frame_crc_engine_top_test;
  import mbcrc_pkg::*;

  localparam int MAX_FRAME      = 256;
  localparam int MIN_FRAME      = 4;
  localparam int RANDOM_WORDS   = 170;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;

  typedef enum int {
    FAULT_NONE,
    FAULT_CRC,
    FAULT_SHORT,
    FAULT_EXTRA
  } frame_fault_e;

  typedef struct {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       frame_end;
    status_e    status;
    logic [8:0] frame_length;
  } crc_result_t;

  class frame_scoreboard #(int MAX_LEN = 256, int MIN_LEN = 4);
    logic [15:0]  crc_acc;
    logic [8:0]   word_count;
    logic [7:0]   pdu_expect;
    logic         check_mode;
    logic         open_frame;
    crc_result_t  pending[$];
    int           errors;

    function new();
      crc_acc    = CRC_INIT;
      word_count = '0;
      pdu_expect = '0;
      check_mode = OP_BUILD;
      open_frame = 1'b0;
      errors     = 0;
    endfunction

    // reflected CRC-16, one input bit per pass, lsb first
    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int i = 0; i < 8; i++) begin
        fb = r[0] ^ d[i];
        r  = r >> 1;
        if (fb) r = r ^ CRC_POLY;
      end
      return r;
    endfunction

    function void queue_result(logic [7:0] b, kind_e k, logic fe, status_e st,
                               logic [8:0] len);
      crc_result_t r;
      r.out_byte     = b;
      r.kind         = k;
      r.frame_end    = fe;
      r.status       = st;
      r.frame_length = len;
      pending.push_back(r);
    endfunction

    function void note_word(logic op, logic [7:0] d, logic last, logic [7:0] pdu);
      int n;
      int adu;
      if (!open_frame) begin
        check_mode = op;
        pdu_expect = pdu;
        crc_acc    = CRC_INIT;
        word_count = '0;
        open_frame = 1'b1;
      end
      adu = int'(pdu_expect) + 3;
      // check mode stops the CRC at address + PDU + 2
      if (check_mode == OP_BUILD || int'(word_count) < adu) crc_acc = crc_step(crc_acc, d);
      if (word_count < COUNT_SAT) word_count = word_count + 9'd1;
      n = int'(word_count);
      if (check_mode == OP_BUILD) begin
        queue_result(d, KIND_ECHO, 1'b0, ST_OK, 9'd0);
        if (last) begin
          if (n == 1)
            queue_result(8'h00, KIND_STATUS, 1'b1, ST_EMPTY, 9'd0);
          else if (n + 2 > MAX_LEN)
            queue_result(8'h00, KIND_STATUS, 1'b1, ST_TOO_BIG, 9'd0);
          else if (n + 2 < MIN_LEN)
            queue_result(8'h00, KIND_STATUS, 1'b1, ST_TOO_SMALL, 9'd0);
          else begin
            queue_result(crc_acc[7:0], KIND_CRC, 1'b0, ST_OK, 9'd0);
            queue_result(crc_acc[15:8], KIND_CRC, 1'b1, ST_OK, 9'(n + 2));
          end
        end
      end else if (last) begin
        if (n < MIN_LEN || n < adu)
          queue_result(8'h00, KIND_STATUS, 1'b1, ST_BAD_SIZE, 9'd0);
        else if (crc_acc != 16'h0000)
          queue_result(8'h00, KIND_STATUS, 1'b1, ST_BAD_CRC, 9'd0);
        else
          queue_result(8'h00, KIND_STATUS, 1'b1, ST_OK, 9'(adu));
      end
      if (last) open_frame = 1'b0;
    endfunction

    task report(string msg);
      errors++;
      $display("mismatch: %s", msg);
    endtask

    task check_result(logic [7:0] ob, logic [1:0] k, logic fe, logic [2:0] st,
                      logic [8:0] len);
      crc_result_t r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word byte %02h kind %0d status %0d", ob, k, st));
        return;
      end
      r = pending.pop_front();
      if (ob !== r.out_byte)
        report($sformatf("out_byte %02h, expected %02h", ob, r.out_byte));
      if (k !== r.kind)
        report($sformatf("kind %0d, expected %0d", k, r.kind));
      if (fe !== r.frame_end)
        report($sformatf("frame_end %0b, expected %0b", fe, r.frame_end));
      if (st !== r.status)
        report($sformatf("status %0d, expected %0d", st, r.status));
      if (len !== r.frame_length)
        report($sformatf("frame_length %0d, expected %0d", len, r.frame_length));
    endtask
  endclass

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       op_i        = OP_BUILD;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_i      = 1'b0;
  logic [7:0] pdu_size_i  = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic [1:0] kind_o;
  logic       frame_end_o;
  logic [2:0] status_o;
  logic [8:0] frame_length_o;

  frame_scoreboard #(MAX_FRAME, MIN_FRAME) sb;
  bit tx_eager    = 1'b0;
  bit rx_eager    = 1'b0;
  bit rx_hold_req = 1'b0;
  int words_sent  = 0;
  int idle_cycles = 0;

  modbus_rtu_frame_crc_engine_top #(
    .MAX_FRAME(MAX_FRAME),
    .MIN_FRAME(MIN_FRAME)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .data_byte_i   (data_byte_i),
    .last_i        (last_i),
    .pdu_size_i    (pdu_size_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_o    (out_byte_o),
    .kind_o        (kind_o),
    .frame_end_o   (frame_end_o),
    .status_o      (status_o),
    .frame_length_o(frame_length_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic send_word(logic op, logic [7:0] d, logic last, logic [7:0] pdu);
    int gap;
    gap = tx_eager ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    op_i        <= op;
    data_byte_i <= d;
    last_i      <= last;
    pdu_size_i  <= pdu;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(op, d, last, pdu);
    words_sent++;
  endtask

  // fill < 0 gives random bytes; op and pdu_size after the first word are don't-care
  task automatic send_build_frame(int len, int fill);
    logic [7:0] d;
    for (int i = 0; i < len; i++) begin
      d = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      send_word((i == 0) ? OP_BUILD : 1'($urandom_range(0, 1)), d, i == len - 1,
                8'($urandom_range(0, 253)));
    end
  endtask

  task automatic send_check_frame(int pdu_len, int pdu_field, frame_fault_e fault);
    logic [7:0]  frame_q[$];
    logic [15:0] crc;
    int          idx;
    int          cut;
    crc = CRC_INIT;
    for (int i = 0; i < pdu_len + 1; i++) begin
      frame_q.push_back(8'($urandom_range(0, 255)));
      crc = sb.crc_step(crc, frame_q[i]);
    end
    frame_q.push_back(crc[7:0]);
    frame_q.push_back(crc[15:8]);
    case (fault)
      FAULT_CRC: begin
        idx = $urandom_range(0, frame_q.size() - 1);
        frame_q[idx] = frame_q[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      FAULT_SHORT: begin
        cut = $urandom_range(1, 2);
        repeat (cut) if (frame_q.size() > 1) void'(frame_q.pop_back());
      end
      FAULT_EXTRA: begin
        repeat ($urandom_range(1, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    for (int i = 0; i < frame_q.size(); i++)
      send_word((i == 0) ? OP_CHECK : 1'($urandom_range(0, 1)), frame_q[i],
                i == frame_q.size() - 1,
                (i == 0) ? 8'(pdu_field) : 8'($urandom_range(0, 253)));
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, eager stretches, one long hold-off on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = HOLD_CYCLES;
      end else begin
        stall = rx_eager ? 0 : $urandom_range(0, 14);
      end
      if ($urandom_range(0, 19) == 0) rx_eager = !rx_eager;
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_byte_o, kind_o, frame_end_o, status_o, frame_length_o);
    end
  end

  initial begin
    int  start_words;
    int  sel;
    bit  hold_done;
    bit  drain_done;
    sb = new();
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty PDU, extremes of data, shortest valid frames
    send_build_frame(1, 8'h00);
    send_build_frame(1, 8'hFF);
    send_build_frame(2, 8'h00);
    send_build_frame(6, 8'hFF);
    // check mode: good, below minimum, bad CRC, short, trailing extras, mismatched size fields
    send_check_frame(1, 1, FAULT_NONE);
    send_check_frame(0, 0, FAULT_NONE);
    send_check_frame(4, 4, FAULT_CRC);
    send_check_frame(3, 3, FAULT_SHORT);
    send_check_frame(2, 2, FAULT_EXTRA);
    send_check_frame(5, 6, FAULT_NONE);
    send_check_frame(5, 4, FAULT_NONE);
    send_word(OP_CHECK, 8'hFF, 1'b1, 8'd253);
    wait_for_results();

    start_words = words_sent;
    while (words_sent - start_words < RANDOM_WORDS) begin
      tx_eager = ($urandom_range(0, 3) == 0);
      if (!hold_done && words_sent - start_words > 60) begin
        // receiver stops while words keep coming, so the engine backs up
        hold_done   = 1'b1;
        rx_hold_req = 1'b1;
        tx_eager    = 1'b1;
        send_build_frame(20, -1);
      end
      if (!drain_done && words_sent - start_words > 140) begin
        drain_done = 1'b1;
        wait_for_results();
      end
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2, 3: send_build_frame($urandom_range(1, 10), -1);
        4, 5, 6: begin
          sel = $urandom_range(0, 8);
          send_check_frame(sel, sel, FAULT_NONE);
        end
        7: begin
          sel = $urandom_range(1, 8);
          send_check_frame(sel, sel, FAULT_CRC);
        end
        8: begin
          sel = $urandom_range(1, 8);
          send_check_frame(sel, sel, $urandom_range(0, 1) ? FAULT_SHORT : FAULT_EXTRA);
        end
        default: begin
          // noise: random length with a random size field
          sel = $urandom_range(1, 6);
          for (int i = 0; i < sel; i++)
            send_word((i == 0) ? OP_CHECK : 1'($urandom_range(0, 1)),
                      8'($urandom_range(0, 255)), i == sel - 1, 8'($urandom_range(0, 253)));
        end
      endcase
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
